// File: hdl/plk_pkg.sv
package plk_pkg;

    localparam int MAX_DOTS_DEF = 9;
    localparam int DOT_W        = 4;
    localparam int HOLD_W       = 16;
    localparam int DEFAULT_LEN  = 5;

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 16'd3000;
    localparam logic [HOLD_W-1:0] HOLD_MAX       = 16'hFFFF;

    localparam logic REQ_DOT  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOCKED      = 2'd0,
        MODE_UNLOCKED    = 2'd1,
        MODE_REGISTERING = 2'd2,
        MODE_CONFIRMING  = 2'd3
    } plk_mode_t;

    typedef struct packed {
        logic             req_type;
        logic [DOT_W-1:0] dot;
        logic             last_dot;
        logic             button_level;
    } plk_item_t;

    typedef struct packed {
        logic      result_kind;
        logic      accepted;
        plk_mode_t lock_mode;
    } plk_result_t;

    function automatic logic [DOT_W-1:0] default_dot(input int idx);
        logic [DOT_W-1:0] d;
        case (idx)
            0:       d = 4'd0;
            1:       d = 4'd1;
            2:       d = 4'd2;
            3:       d = 4'd5;
            4:       d = 4'd8;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/plk_in_reg.sv
module plk_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  plk_pkg::plk_item_t  item_in,
    input  logic                pop,
    output logic                stg_valid,
    output plk_pkg::plk_item_t  stg_item
);
    import plk_pkg::*;

    logic      valid_reg;
    plk_item_t item_reg;

    assign item_ready = !valid_reg || pop;
    assign stg_valid  = valid_reg;
    assign stg_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// File: hdl/plk_core.sv
module plk_core #(
    parameter int MAX_DOTS = plk_pkg::MAX_DOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [plk_pkg::HOLD_W-1:0]    cfg_wdata,
    input  logic                          stg_valid,
    input  plk_pkg::plk_item_t            stg_item,
    input  logic                          out_free,
    output logic                          pop,
    output logic                          res_valid,
    output plk_pkg::plk_result_t          res
);
    import plk_pkg::*;

    localparam int CNT_W = $clog2(MAX_DOTS + 1);
    localparam int IDX_W = $clog2(MAX_DOTS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DOTS);

    plk_mode_t          mode_reg, mode_next;
    logic [DOT_W-1:0]   stored_reg [MAX_DOTS];
    logic [DOT_W-1:0]   pending_reg [MAX_DOTS];
    logic [CNT_W-1:0]   stored_len_reg, stored_len_next;
    logic [CNT_W-1:0]   pending_len_reg, pending_len_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               mm_reg, mm_next;
    logic               ovf_reg, ovf_next;
    logic               held_reg, held_next;
    logic [HOLD_W-1:0]  hold_cnt_reg, hold_cnt_next;
    logic [HOLD_W-1:0]  hold_ticks_reg;

    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   cnt_dot;
    logic               mm_dot;
    logic               ovf_dot;
    logic               full;
    logic [IDX_W-1:0]   idx;
    logic [HOLD_W-1:0]  hold_inc;
    logic               pend_we;
    logic               copy_en;
    logic               emit;
    logic               emit_kind;
    logic               emit_acc;

    assign pop      = stg_valid && out_free;
    assign full     = (cnt_reg == CNT_FULL);
    assign idx      = cnt_reg[IDX_W-1:0];
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign hold_inc = (hold_cnt_reg == HOLD_MAX) ? hold_cnt_reg : hold_cnt_reg + HOLD_W'(1);

    // next state
    always_comb
    begin
        mode_next        = mode_reg;
        stored_len_next  = stored_len_reg;
        pending_len_next = pending_len_reg;
        cnt_next         = cnt_reg;
        mm_next          = mm_reg;
        ovf_next         = ovf_reg;
        held_next        = held_reg;
        hold_cnt_next    = hold_cnt_reg;
        cnt_dot          = cnt_reg;
        mm_dot           = mm_reg;
        ovf_dot          = ovf_reg;
        pend_we          = 1'b0;
        copy_en          = 1'b0;
        emit             = 1'b0;
        emit_kind        = KIND_VERDICT;
        emit_acc         = 1'b0;

        if (pop)
        begin
            if (stg_item.req_type == REQ_TICK)
            begin
                if (!stg_item.button_level)
                begin
                    held_next = 1'b0;
                end
                else if (!held_reg)
                begin
                    held_next     = 1'b1;
                    hold_cnt_next = '0;
                end
                else
                begin
                    hold_cnt_next = hold_inc;
                    if (hold_inc >= hold_ticks_reg)
                    begin
                        held_next     = 1'b0;
                        hold_cnt_next = '0;
                        if (mode_reg inside {MODE_LOCKED, MODE_UNLOCKED})
                        begin
                            mode_next = MODE_REGISTERING;
                            cnt_next  = '0;
                            mm_next   = 1'b0;
                            ovf_next  = 1'b0;
                            emit      = 1'b1;
                            emit_kind = KIND_REQUEST;
                            emit_acc  = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (full)
                begin
                    ovf_dot = 1'b1;
                end
                else
                begin
                    cnt_dot = cnt_inc;
                    case (mode_reg)
                        MODE_LOCKED:
                        begin
                            if (stored_reg[idx] != stg_item.dot)
                            begin
                                mm_dot = 1'b1;
                            end
                        end
                        MODE_CONFIRMING:
                        begin
                            if (pending_reg[idx] != stg_item.dot)
                            begin
                                mm_dot = 1'b1;
                            end
                        end
                        MODE_REGISTERING:
                        begin
                            pend_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (!stg_item.last_dot)
                begin
                    cnt_next = cnt_dot;
                    mm_next  = mm_dot;
                    ovf_next = ovf_dot;
                end
                else
                begin
                    cnt_next  = '0;
                    mm_next   = 1'b0;
                    ovf_next  = 1'b0;
                    emit      = 1'b1;
                    emit_kind = KIND_VERDICT;
                    if (!ovf_dot)
                    begin
                        case (mode_reg)
                            MODE_LOCKED:
                            begin
                                if (!mm_dot && cnt_dot == stored_len_reg)
                                begin
                                    mode_next = MODE_UNLOCKED;
                                    emit_acc  = 1'b1;
                                end
                            end
                            MODE_REGISTERING:
                            begin
                                pending_len_next = cnt_dot;
                                mode_next        = MODE_CONFIRMING;
                                emit_acc         = 1'b1;
                            end
                            MODE_CONFIRMING:
                            begin
                                if (!mm_dot && cnt_dot == pending_len_reg)
                                begin
                                    copy_en         = 1'b1;
                                    stored_len_next = cnt_dot;
                                    mode_next       = MODE_LOCKED;
                                    emit_acc        = 1'b1;
                                end
                                else
                                begin
                                    mode_next = MODE_REGISTERING;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    // result beat
    always_comb
    begin
        res_valid       = emit;
        res.result_kind = emit_kind;
        res.accepted    = emit_acc;
        res.lock_mode   = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_LOCKED;
            stored_len_reg  <= CNT_W'(DEFAULT_LEN);
            pending_len_reg <= '0;
            cnt_reg         <= '0;
            mm_reg          <= 1'b0;
            ovf_reg         <= 1'b0;
            held_reg        <= 1'b0;
            hold_cnt_reg    <= '0;
            hold_ticks_reg  <= HOLD_TICKS_RST;
            for (int i = 0; i < MAX_DOTS; i++)
            begin
                stored_reg[i] <= default_dot(i);
            end
        end
        else
        begin
            mode_reg        <= mode_next;
            stored_len_reg  <= stored_len_next;
            pending_len_reg <= pending_len_next;
            cnt_reg         <= cnt_next;
            mm_reg          <= mm_next;
            ovf_reg         <= ovf_next;
            held_reg        <= held_next;
            hold_cnt_reg    <= hold_cnt_next;
            if (cfg_we)
            begin
                hold_ticks_reg <= cfg_wdata;
            end
            if (copy_en)
            begin
                for (int i = 0; i < MAX_DOTS; i++)
                begin
                    stored_reg[i] <= pending_reg[i];
                end
            end
        end
    end

    // pending pattern, no reset
    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pending_reg[idx] <= stg_item.dot;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count beyond limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow flag without full entry");

    a_req_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_kind == KIND_REQUEST) |->
            (mode_reg == MODE_LOCKED || mode_reg == MODE_UNLOCKED))
        else $error("enrolment request from wrong mode");

    a_req_next: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_kind == KIND_REQUEST) |=>
            (mode_reg == MODE_REGISTERING && cnt_reg == '0))
        else $error("request did not enter registering");

    a_emit_pop: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> pop)
        else $error("result without consumed beat");

endmodule

// File: hdl/plk_out_reg.sv
module plk_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  res_valid,
    input  plk_pkg::plk_result_t  res,
    output logic                  out_free,
    output logic                  result_valid,
    input  logic                  result_ready,
    output plk_pkg::plk_result_t  result
);
    import plk_pkg::*;

    logic        valid_reg;
    plk_result_t res_reg;

    assign out_free     = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: hdl/pattern_lock_with_enrollment_top.sv
// channel  | handshake                   | payload
// item     | item_valid / item_ready     | req_type, dot, last_dot, button_level
// result   | result_valid / result_ready | result_kind, accepted, lock_mode
// config   | cfg_we                      | cfg_wdata (hold_ticks)
//
// one beat per cycle sustained while results are taken; a beat is registered,
// then decided combinationally against the lock state, its result registered
// asynchronous active-low reset restores the default pattern and locked mode
// a stalled result holds the decision stage; the input register keeps taking
// beats until it is full
module pattern_lock_with_enrollment_top #(
    parameter int MAX_DOTS = plk_pkg::MAX_DOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [plk_pkg::HOLD_W-1:0]  cfg_wdata,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        req_type,
    input  logic [plk_pkg::DOT_W-1:0]   dot,
    input  logic                        last_dot,
    input  logic                        button_level,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        result_kind,
    output logic                        accepted,
    output logic [1:0]                  lock_mode
);
    import plk_pkg::*;

    plk_item_t   item_in;
    plk_item_t   stg_item;
    plk_result_t res;
    plk_result_t result;
    logic        stg_valid;
    logic        pop;
    logic        res_valid;
    logic        out_free;

    assign item_in.req_type     = req_type;
    assign item_in.dot          = dot;
    assign item_in.last_dot     = last_dot;
    assign item_in.button_level = button_level;

    plk_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_in    (item_in),
        .pop        (pop),
        .stg_valid  (stg_valid),
        .stg_item   (stg_item)
    );

    plk_core #(
        .MAX_DOTS (MAX_DOTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stg_valid (stg_valid),
        .stg_item  (stg_item),
        .out_free  (out_free),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    plk_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (pop),
        .res_valid    (res_valid),
        .res          (res),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign result_kind = result.result_kind;
    assign accepted    = result.accepted;
    assign lock_mode   = result.lock_mode;

endmodule

// File: bench/pattern_lock_with_enrollment_top_tb.sv
module pattern_lock_with_enrollment_top_tb;

    import plk_pkg::*;

    localparam int MAX_DOTS    = MAX_DOTS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 4;

    typedef struct packed {
        plk_mode_t              mode;
        logic [15:0][DOT_W-1:0] stored;
        logic [4:0]             stored_len;
        logic [15:0][DOT_W-1:0] pending;
        logic [15:0]            written;
        logic [4:0]             pending_len;
        logic [4:0]             entry_count;
        logic                   mismatch;
        logic                   overflow;
        logic                   held;
        logic [HOLD_W-1:0]      hold_count;
        logic [HOLD_W-1:0]      hold_ticks;
    } lock_state_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [HOLD_W-1:0] cfg_wdata    = '0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    logic              req_type     = 1'b0;
    logic [DOT_W-1:0]  dot          = '0;
    logic              last_dot     = 1'b0;
    logic              button_level = 1'b0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              result_kind;
    logic              accepted;
    logic [1:0]        lock_mode;

    plk_item_t   beats_to_send[$];
    plk_result_t verdicts_due[$];
    lock_state_t lock_now;
    lock_state_t lock_plan;
    plk_item_t   offer;
    plk_item_t   taken;
    plk_result_t due_now;
    plk_result_t verdict;
    bit          verdict_hit;

    int idle_pct      = 9;
    int beats_queued  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int hold_off_left = 0;
    int next_hold_off = 40;

    pattern_lock_with_enrollment_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .req_type     (req_type),
        .dot          (dot),
        .last_dot     (last_dot),
        .button_level (button_level),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .accepted     (accepted),
        .lock_mode    (lock_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic lock_state_t lock_reset_state();
        lock_state_t s;
        s = '0;
        s.mode       = MODE_LOCKED;
        // default pattern 0,1,2,5,8, first dot in the lowest nibble
        s.stored     = 64'h8_5210;
        s.stored_len = 5'(DEFAULT_LEN);
        s.hold_ticks = HOLD_TICKS_RST;
        return s;
    endfunction

    task automatic lock_step(inout lock_state_t s, input plk_item_t b,
                             output bit hit, output plk_result_t r);
        int idx;
        int i;
        hit = 1'b0;
        r   = '0;
        if (b.req_type == REQ_TICK)
        begin
            if (!b.button_level)
                s.held = 1'b0;
            else if (!s.held)
            begin
                s.held       = 1'b1;
                s.hold_count = '0;
            end
            else
            begin
                if (s.hold_count != HOLD_MAX)
                    s.hold_count = s.hold_count + 1'b1;
                if (s.hold_count >= s.hold_ticks)
                begin
                    s.held       = 1'b0;
                    s.hold_count = '0;
                    if (s.mode == MODE_LOCKED || s.mode == MODE_UNLOCKED)
                    begin
                        s.mode        = MODE_REGISTERING;
                        s.entry_count = '0;
                        s.mismatch    = 1'b0;
                        s.overflow    = 1'b0;
                        hit           = 1'b1;
                        r.result_kind = KIND_REQUEST;
                        r.accepted    = 1'b1;
                        r.lock_mode   = s.mode;
                    end
                end
            end
        end
        else
        begin
            if (s.entry_count >= MAX_DOTS)
                s.overflow = 1'b1;
            else
            begin
                idx = s.entry_count;
                case (s.mode)
                    MODE_LOCKED:
                        if (s.stored[idx] != b.dot)
                            s.mismatch = 1'b1;
                    MODE_CONFIRMING:
                        if (s.pending[idx] != b.dot)
                            s.mismatch = 1'b1;
                    MODE_REGISTERING:
                    begin
                        s.pending[idx] = b.dot;
                        s.written[idx] = 1'b1;
                    end
                    default:
                        ;
                endcase
                s.entry_count = s.entry_count + 1'b1;
            end
            if (b.last_dot)
            begin
                if (!s.overflow)
                begin
                    case (s.mode)
                        MODE_LOCKED:
                            if (!s.mismatch && s.entry_count == s.stored_len)
                            begin
                                s.mode     = MODE_UNLOCKED;
                                r.accepted = 1'b1;
                            end
                        MODE_REGISTERING:
                        begin
                            s.pending_len = s.entry_count;
                            s.mode        = MODE_CONFIRMING;
                            r.accepted    = 1'b1;
                        end
                        MODE_CONFIRMING:
                            if (!s.mismatch && s.entry_count == s.pending_len)
                            begin
                                for (i = 0; i < s.entry_count; i++)
                                    s.stored[i] = s.pending[i];
                                s.stored_len = s.entry_count;
                                s.mode       = MODE_LOCKED;
                                r.accepted   = 1'b1;
                            end
                            else
                                s.mode = MODE_REGISTERING;
                        default:
                            ;
                    endcase
                end
                s.entry_count = '0;
                s.mismatch    = 1'b0;
                s.overflow    = 1'b0;
                hit           = 1'b1;
                r.result_kind = KIND_VERDICT;
                r.lock_mode   = s.mode;
            end
        end
    endtask

    // a confirming dot at this offset would be compared with a pending slot never written
    function automatic bit reads_blank(input int ahead);
        int idx;
        idx = lock_plan.entry_count + ahead;
        return lock_plan.mode == MODE_CONFIRMING && idx < MAX_DOTS && !lock_plan.written[idx];
    endfunction

    task automatic queue_beat(input plk_item_t b);
        bit          hit;
        plk_result_t r;
        lock_step(lock_plan, b, hit, r);
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_tick(input logic level);
        plk_item_t b;
        b.req_type     = REQ_TICK;
        b.dot          = 4'($urandom_range(15));
        b.last_dot     = 1'($urandom_range(1));
        b.button_level = level;
        queue_beat(b);
    endtask

    task automatic queue_dot(input logic [DOT_W-1:0] d, input bit last, output bit closed);
        plk_item_t b;
        closed = 1'b1;
        if (!reads_blank(0))
        begin
            closed         = last || reads_blank(1);
            b.req_type     = REQ_DOT;
            b.dot          = d;
            b.last_dot     = closed;
            b.button_level = 1'($urandom_range(1));
            queue_beat(b);
        end
    endtask

    task automatic queue_press(input int n, input bit release_after);
        repeat (n)
            queue_tick(1'b1);
        if (release_after)
            queue_tick(1'b0);
    endtask

    task automatic queue_long_press();
        int h;
        h = lock_plan.hold_ticks;
        if (h <= 16 && $urandom_range(4) != 0)
            queue_press(((h == 0) ? 1 : h) + 1 + $urandom_range(1), $urandom_range(4) != 0);
        else
            queue_press($urandom_range(1, (h == 0 || h > 16) ? 3 : h), 1'b1);
    endtask

    task automatic queue_pattern(input logic [63:0] pat, input int len, input bit chatty);
        bit closed;
        int k;
        for (k = 0; k < len; k++)
        begin
            queue_dot(pat[4*k +: 4], k == len - 1, closed);
            if (closed)
                break;
            if (chatty && $urandom_range(99) < 6)
            begin
                if ($urandom_range(3) == 0)
                    queue_long_press();
                else
                    queue_tick(1'($urandom_range(1)));
            end
        end
    endtask

    // replay a known pattern, now and then with a wrong dot or a wrong length
    task automatic queue_known(input logic [63:0] pat, input int len);
        int n;
        n = len;
        case ($urandom_range(7))
            0: pat[4*$urandom_range(len - 1) +: 4] = 4'($urandom_range(15));
            1: n = len + 1;
            2: n = (len > 1) ? len - 1 : len;
            default: ;
        endcase
        queue_pattern(pat, n, 1'b1);
    endtask

    task automatic queue_noise();
        plk_item_t b;
        bit        closed;
        repeat ($urandom_range(1, 3))
        begin
            b.req_type     = 1'($urandom_range(1));
            b.dot          = 4'($urandom_range(15));
            b.last_dot     = 1'($urandom_range(1));
            b.button_level = 1'($urandom_range(1));
            if (b.req_type == REQ_TICK)
                queue_beat(b);
            else
                queue_dot(b.dot, b.last_dot, closed);
        end
    endtask

    task automatic queue_episode();
        logic [63:0] pat;
        int          pick;
        int          len;
        pick = $urandom_range(99);
        pat  = {$urandom, $urandom};
        len  = ($urandom_range(9) == 0) ? $urandom_range(MAX_DOTS + 1, 12)
                                         : $urandom_range(1, MAX_DOTS);
        case (lock_plan.mode)
            MODE_LOCKED:
                if (pick < 45)
                    queue_known(lock_plan.stored, lock_plan.stored_len);
                else if (pick < 65)
                    queue_pattern(pat, len, 1'b1);
                else if (pick < 85)
                    queue_long_press();
                else
                    queue_noise();
            MODE_UNLOCKED:
                if (pick < 55)
                    queue_long_press();
                else if (pick < 75)
                    queue_pattern(pat, len, 1'b1);
                else
                    queue_noise();
            MODE_REGISTERING:
                if (pick < 70)
                    queue_pattern(pat, len, 1'b1);
                else if (pick < 85)
                    queue_long_press();
                else
                    queue_noise();
            default:
                if (pick < 55)
                    queue_known(lock_plan.pending, lock_plan.pending_len);
                else if (pick < 75)
                    queue_pattern(pat, len, 1'b1);
                else if (pick < 85)
                    queue_long_press();
                else
                    queue_noise();
        endcase
    endtask

    task automatic queue_random(input int n);
        int target;
        target = beats_queued + n;
        while (beats_queued < target)
            queue_episode();
    endtask

    task automatic wait_quiet();
        while (beats_to_send.size() != 0 || item_valid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_hold(input logic [HOLD_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lock_now.hold_ticks  = v;
        lock_plan.hold_ticks = v;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                taken = {req_type, dot, last_dot, button_level};
                lock_step(lock_now, taken, verdict_hit, verdict);
                if (verdict_hit)
                    verdicts_due.push_back(verdict);
            end
            if (!item_valid || item_ready)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    offer = beats_to_send.pop_front();
                    item_valid   <= 1'b1;
                    req_type     <= offer.req_type;
                    dot          <= offer.dot;
                    last_dot     <= offer.last_dot;
                    button_level <= offer.button_level;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (verdicts_due.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    due_now = verdicts_due.pop_front();
                    if (result_kind !== due_now.result_kind)
                        report_mismatch($sformatf("result_kind got %0d want %0d",
                                                  result_kind, due_now.result_kind));
                    if (accepted !== due_now.accepted)
                        report_mismatch($sformatf("accepted got %0d want %0d",
                                                  accepted, due_now.accepted));
                    if (lock_mode !== due_now.lock_mode)
                        report_mismatch($sformatf("lock_mode got %0d want %0d",
                                                  lock_mode, due_now.lock_mode));
                end
            end
            result_ready <= (hold_off_left == 0) && ($urandom_range(99) >= idle_pct);
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
        else if (results_seen == next_hold_off)
        begin
            hold_off_left <= 300;
            next_hold_off <= next_hold_off + 110;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("pattern_lock_with_enrollment_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        lock_now  = lock_reset_state();
        lock_plan = lock_now;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset hold time: wrong, overlong and default patterns, presses too short to enrol
        queue_tick(1'b0);
        queue_pattern(64'h3F, 2, 1'b0);
        queue_pattern(64'h0123_4567_89AB_CDEF, 10, 1'b0);
        queue_pattern(64'h8_5210, 5, 1'b0);
        queue_pattern(64'hF, 1, 1'b0);
        queue_press(24, 1'b1);
        queue_pattern(64'h70F, 3, 1'b0);
        queue_pattern(64'h60F, 3, 1'b0);
        queue_pattern(64'h0123_4567_89AB_CDEF, 10, 1'b0);
        queue_pattern(64'hF43, 3, 1'b0);
        queue_pattern(64'hF43, 3, 1'b0);
        queue_pattern(64'hF43, 3, 1'b0);
        wait_quiet();

        // hold of one: press between patterns to enrol, press while confirming
        set_hold(16'd1);
        queue_pattern(64'h92, 2, 1'b0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_pattern(64'h6, 1, 1'b0);
        queue_press(2, 1'b1);
        queue_pattern(64'h6, 1, 1'b0);
        queue_pattern(64'h6, 1, 1'b0);
        queue_random(450);
        wait_quiet();

        set_hold(16'd0);
        queue_press(2, 1'b1);
        queue_random(150);
        wait_quiet();

        idle_pct = 0;
        set_hold(16'($urandom_range(2, 6)));
        queue_random(450);
        wait_quiet();

        idle_pct = 9;
        set_hold(HOLD_MAX);
        while (lock_plan.mode == MODE_REGISTERING || lock_plan.mode == MODE_CONFIRMING)
            queue_episode();
        queue_press(40, 1'b1);
        queue_random(100);
        wait_quiet();

        set_hold(16'($urandom_range(1, 4)));
        queue_random(450);
        wait_quiet();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("pattern_lock_with_enrollment_top regression: pass");
        else
            $display("pattern_lock_with_enrollment_top regression: fail");
        $finish;
    end

endmodule
